### rtl/oaht_pkg.sv
// Shared constants, codes and port structs of the open-addressed handle table.
// No dependencies; every other file of the block imports this package.
package oaht_pkg;

    localparam int TABLE_SLOTS = 128;                 // power of two
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int KEY_W       = 64;
    localparam int ACT_W       = 2;
    localparam int STAT_W      = 3;
    localparam int IDX_W       = 7;                   // result slot field width

    // Hash finalizer: only the low MIX_SHIFT + SLOT_W product bits reach the slot.
    localparam int              MIX_SHIFT = 33;
    localparam logic [KEY_W-1:0] MIX_MULT = 64'hff51_afd7_ed55_8ccd;
    localparam int              PROD_W    = MIX_SHIFT + SLOT_W;
    localparam int              HALF_W    = (PROD_W + 1) / 2;
    localparam int              HIGH_W    = PROD_W - HALF_W;

    // Entry encodings
    localparam logic [KEY_W-1:0] SLOT_EMPTY = KEY_W'(0);
    localparam logic [KEY_W-1:0] SLOT_TOMB  = KEY_W'(1);

    // Actions
    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ERASE  = 2'd2;

    // Result status
    localparam logic [STAT_W-1:0] ST_FOUND    = 3'd0;
    localparam logic [STAT_W-1:0] ST_INSERTED = 3'd1;
    localparam logic [STAT_W-1:0] ST_ABSENT   = 3'd2;
    localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STAT_W-1:0] ST_ERASED   = 3'd4;
    localparam logic [STAT_W-1:0] ST_RESERVED = 3'd5;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
    } t_rd_req;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        logic [KEY_W-1:0]  data;
    } t_wr_req;

endpackage

### rtl/oaht_req_if.sv
// Request channel of the handle table: valid/ready plus action and key.
// Depends on oaht_pkg.
interface oaht_req_if;
    import oaht_pkg::*;

    logic             valid;
    logic             ready;
    logic [ACT_W-1:0] action;
    logic [KEY_W-1:0] key;

    modport source (output valid, output action, output key, input ready);
    modport sink   (input valid, input action, input key, output ready);
endinterface

### rtl/oaht_rsp_if.sv
// Response channel of the handle table: valid/ready plus status and slot index.
// Depends on oaht_pkg.
interface oaht_rsp_if;
    import oaht_pkg::*;

    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  slot_index;

    modport source (output valid, output status, output slot_index, input ready);
    modport sink   (input valid, input status, input slot_index, output ready);
endinterface

### rtl/open_addressed_handle_table.sv
// Open-addressed handle table with linear probing and tombstones.
// Depends on oaht_pkg, oaht_req_if, oaht_rsp_if, oaht_hash and oaht_store.
//
// Usage:
//   i_req carries one item: an action (insert-or-lookup, lookup, erase) and a
//   64-bit key. o_rsp returns one item per request: status and slot index.
//   Both channels complete a transfer when valid and ready are high at a
//   rising edge of i_clk.
// Timing:
//   The block works on one item at a time. After acceptance it computes
//   the hash (partial products, then the add), then walks the table one
//   slot per cycle through the key memory's single read port. The walk
//   visits from 1 to TABLE_SLOTS slots. The result lands in the output
//   register at the end of the last probe if that register is free, else
//   in the holding stage. Keys 0 and 1 skip the hash and the walk and are
//   answered as reserved through the holding stage.
// Stalls:
//   A waiting result blocks i_req: no new item is accepted while the
//   result waits in a holding stage until the output register drains,
//   so a stalled receiver adds cycles, never loss.
// Reset:
//   i_rst_n is synchronous, active low. Every slot reads as empty right after
//   reset (valid bits cleared together, no clearing pass).
module open_addressed_handle_table (
    input  logic      i_clk,
    input  logic      i_rst_n,
    oaht_req_if.sink   i_req,
    oaht_rsp_if.source o_rsp
);
    import oaht_pkg::*;

    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_HASH1,
        S_HASH2,
        S_PROBE,
        S_HOLD
    } t_state;

    t_state            r_state, n_state;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [ACT_W-1:0]  r_action, n_action;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [SLOT_W-1:0] r_count, n_count;
    logic              r_have_tomb, n_have_tomb;
    logic [SLOT_W-1:0] r_tomb, n_tomb;
    logic [STAT_W-1:0] r_res_status, n_res_status;
    logic [IDX_W-1:0]  r_res_slot, n_res_slot;
    logic              r_rsp_valid, n_rsp_valid;
    logic [STAT_W-1:0] r_rsp_status, n_rsp_status;
    logic [IDX_W-1:0]  r_rsp_slot, n_rsp_slot;

    logic [SLOT_W-1:0] w_home;
    logic [KEY_W-1:0]  w_entry;
    t_rd_req           w_rd;
    t_wr_req           w_wr;
    logic              w_out_free;
    logic              w_hit, w_empty, w_tomb, w_last;
    logic              w_finish;
    logic [STAT_W-1:0] w_fin_status;
    logic [SLOT_W-1:0] w_fin_slot;
    logic [SLOT_W-1:0] w_next_slot;

    oaht_hash u_hash (
        .i_clk  (i_clk),
        .i_load (r_state == S_HASH1),
        .i_key  (r_key),
        .o_home (w_home)
    );

    oaht_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd      (w_rd),
        .i_wr      (w_wr),
        .o_rd_data (w_entry)
    );

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_rsp.valid      = r_rsp_valid;
    assign o_rsp.status     = r_rsp_status;
    assign o_rsp.slot_index = r_rsp_slot;

    assign w_out_free  = !r_rsp_valid || o_rsp.ready;
    assign w_hit       = (w_entry == r_key);
    assign w_empty     = (w_entry == SLOT_EMPTY);
    assign w_tomb      = (w_entry == SLOT_TOMB);
    assign w_last      = (r_count == LAST_SLOT);
    assign w_next_slot = (r_slot == LAST_SLOT) ? '0 : r_slot + SLOT_W'(1);

    // Probe decision on the entry read for r_slot.
    always_comb begin
        w_finish     = 1'b0;
        w_fin_status = ST_ABSENT;
        w_fin_slot   = '0;
        w_wr.en      = 1'b0;
        w_wr.addr    = r_slot;
        w_wr.data    = r_key;
        if (r_state == S_PROBE) begin
            case (r_action)
                ACT_INSERT: begin
                    if (w_hit) begin
                        w_finish     = 1'b1;
                        w_fin_status = ST_FOUND;
                        w_fin_slot   = r_slot;
                    end else if (w_empty || (w_last && (r_have_tomb || w_tomb))) begin
                        // Claim the first tombstone passed, else this slot.
                        w_finish     = 1'b1;
                        w_fin_status = ST_INSERTED;
                        w_fin_slot   = r_have_tomb ? r_tomb : r_slot;
                        w_wr.en      = 1'b1;
                        w_wr.addr    = w_fin_slot;
                    end else if (w_last) begin
                        w_finish     = 1'b1;
                        w_fin_status = ST_FULL;
                    end
                end
                ACT_ERASE: begin
                    if (w_hit) begin
                        w_finish     = 1'b1;
                        w_fin_status = ST_ERASED;
                        w_fin_slot   = r_slot;
                        w_wr.en      = 1'b1;
                        w_wr.data    = SLOT_TOMB;
                    end else if (w_empty || w_last) begin
                        w_finish     = 1'b1;
                    end
                end
                default: begin
                    // Lookup, and the unused code, which acts as lookup.
                    if (w_hit) begin
                        w_finish     = 1'b1;
                        w_fin_status = ST_FOUND;
                        w_fin_slot   = r_slot;
                    end else if (w_empty || w_last) begin
                        w_finish     = 1'b1;
                    end
                end
            endcase
        end
    end

    always_comb begin
        w_rd.en   = 1'b0;
        w_rd.addr = w_home;
        if (r_state == S_HASH2) begin
            w_rd.en = 1'b1;
        end else if (r_state == S_PROBE && !w_finish) begin
            w_rd.en   = 1'b1;
            w_rd.addr = w_next_slot;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_key        = r_key;
        n_action     = r_action;
        n_slot       = r_slot;
        n_count      = r_count;
        n_have_tomb  = r_have_tomb;
        n_tomb       = r_tomb;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_rsp_valid  = r_rsp_valid && !o_rsp.ready;
        n_rsp_status = r_rsp_status;
        n_rsp_slot   = r_rsp_slot;
        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_key    = i_req.key;
                    n_action = i_req.action;
                    if (i_req.key == SLOT_EMPTY || i_req.key == SLOT_TOMB) begin
                        n_res_status = ST_RESERVED;
                        n_res_slot   = '0;
                        n_state      = S_HOLD;
                    end else begin
                        n_state = S_HASH1;
                    end
                end
            end
            S_HASH1: begin
                n_state = S_HASH2;
            end
            S_HASH2: begin
                n_slot      = w_home;
                n_count     = '0;
                n_have_tomb = 1'b0;
                n_state     = S_PROBE;
            end
            S_PROBE: begin
                if (w_finish) begin
                    if (w_out_free) begin
                        n_rsp_valid  = 1'b1;
                        n_rsp_status = w_fin_status;
                        n_rsp_slot   = IDX_W'(w_fin_slot);
                        n_state      = S_IDLE;
                    end else begin
                        n_res_status = w_fin_status;
                        n_res_slot   = IDX_W'(w_fin_slot);
                        n_state      = S_HOLD;
                    end
                end else begin
                    // Remember the first tombstone, then advance one slot.
                    if (w_tomb && !r_have_tomb) begin
                        n_have_tomb = 1'b1;
                        n_tomb      = r_slot;
                    end
                    n_slot  = w_next_slot;
                    n_count = r_count + SLOT_W'(1);
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    n_rsp_valid  = 1'b1;
                    n_rsp_status = r_res_status;
                    n_rsp_slot   = r_res_slot;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
            r_have_tomb <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_rsp_valid  <= n_rsp_valid;
            r_have_tomb  <= n_have_tomb;
            r_key        <= n_key;
            r_action     <= n_action;
            r_slot       <= n_slot;
            r_count      <= n_count;
            r_tomb       <= n_tomb;
            r_res_status <= n_res_status;
            r_res_slot   <= n_res_slot;
            r_rsp_status <= n_rsp_status;
            r_rsp_slot   <= n_rsp_slot;
        end
    end

    // Reserved keys bypass the probe and never touch the store.
    a_reserved_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready &&
         (i_req.key == SLOT_EMPTY || i_req.key == SLOT_TOMB))
        |=> (r_state == S_HOLD && r_res_status == ST_RESERVED))
        else $error("reserved key did not bypass the probe");

    // The walk never visits more slots than the table holds.
    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PROBE && r_count == LAST_SLOT) |=> (r_state != S_PROBE))
        else $error("probe walked past the table size");

    // A store write happens only on the walk's last probe.
    a_write_ends_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr.en |=> (r_state == S_IDLE || r_state == S_HOLD))
        else $error("store written while the walk continues");

    // Results without a slot carry slot index zero.
    a_no_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status == ST_ABSENT || o_rsp.status == ST_FULL ||
                         o_rsp.status == ST_RESERVED))
        |-> (o_rsp.slot_index == '0))
        else $error("slotless result carries a nonzero slot index");

endmodule

### rtl/oaht_hash.sv
// Home-slot hash: finalizer mix, multiply split into registered partial products.
// Depends on oaht_pkg.
module oaht_hash (
    input  logic                       i_clk,
    input  logic                       i_load,
    input  logic [oaht_pkg::KEY_W-1:0] i_key,
    output logic [oaht_pkg::SLOT_W-1:0] o_home
);
    import oaht_pkg::*;

    logic [KEY_W-1:0]       w_mix;
    logic [HALF_W-1:0]      w_xl;
    logic [HIGH_W-1:0]      w_xh;
    logic [HALF_W-1:0]      w_cl;
    logic [HIGH_W-1:0]      w_ch;
    logic [2*HALF_W-1:0]    w_ll;
    logic [HIGH_W+HALF_W-1:0] w_hl;
    logic [HALF_W+HIGH_W-1:0] w_lh;
    logic [2*HALF_W-1:0]    r_pp_ll;
    logic [HIGH_W-1:0]      r_pp_hl;
    logic [HIGH_W-1:0]      r_pp_lh;
    logic [HIGH_W-1:0]      w_cross;
    logic [PROD_W-1:0]      w_prod;

    assign w_mix = i_key ^ (i_key >> MIX_SHIFT);
    assign w_xl  = w_mix[HALF_W-1:0];
    assign w_xh  = w_mix[PROD_W-1:HALF_W];
    assign w_cl  = MIX_MULT[HALF_W-1:0];
    assign w_ch  = MIX_MULT[PROD_W-1:HALF_W];

    assign w_ll = w_xl * w_cl;
    assign w_hl = w_xh * w_cl;
    assign w_lh = w_xl * w_ch;

    // Keep only product bits below PROD_W; cross terms land at HALF_W and up.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pp_ll <= w_ll;
            r_pp_hl <= w_hl[HIGH_W-1:0];
            r_pp_lh <= w_lh[HIGH_W-1:0];
        end
    end

    assign w_cross = r_pp_hl + r_pp_lh;
    assign w_prod  = r_pp_ll[PROD_W-1:0] + {w_cross, {HALF_W{1'b0}}};
    assign o_home  = w_prod[SLOT_W-1:0] ^ w_prod[MIX_SHIFT +: SLOT_W];

endmodule

### rtl/oaht_store.sv
// Key store: one-write one-read synchronous memory with per-entry valid bits.
// An entry never written reads as empty. Depends on oaht_pkg.
module oaht_store (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  oaht_pkg::t_rd_req           i_rd,
    input  oaht_pkg::t_wr_req           i_wr,
    output logic [oaht_pkg::KEY_W-1:0]  o_rd_data
);
    import oaht_pkg::*;

    logic [KEY_W-1:0]       r_mem [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] r_valid;
    logic [KEY_W-1:0]       r_rd_data;
    logic                   r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd.en) begin
                r_rd_valid <= r_valid[i_rd.addr];
            end
        end
    end

    assign o_rd_data = r_rd_valid ? r_rd_data : SLOT_EMPTY;

endmodule
